[rtl/rob_pkg.sv]
// ----------------------------------------------------------------------------
// rob_pkg
// Shared constants and helpers for the in-order result reorder buffer.
// ----------------------------------------------------------------------------
package rob_pkg;

   // Number of slots in the reorder window.
   localparam int WINDOW       = 16;
   localparam int IDX_BITS     = $clog2(WINDOW);
   // Width of the sequence numbers; numbers wrap modulo 2^SEQ_BITS.
   localparam int SEQ_BITS     = 16;
   // Width of the main and the debug word.
   localparam int PAYLOAD_BITS = 64;
   // One memory word holds the debug word above the main word.
   localparam int SLOT_BITS    = 2 * PAYLOAD_BITS;

   typedef logic [IDX_BITS-1:0]     idx_type;
   typedef logic [SEQ_BITS-1:0]     seq_type;
   typedef logic [PAYLOAD_BITS-1:0] payload_type;

   // Next slot index, wrapping at the end of the window.
   function automatic idx_type next_idx(input idx_type idx);
      idx_type result;
      if (idx == idx_type'(WINDOW - 1)) begin
         result = '0;
      end else begin
         result = idx + idx_type'(1);
      end
      return result;
   endfunction

endpackage

[rtl/rob_ram.sv]
// ----------------------------------------------------------------------------
// rob_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rob_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/in_order_result_reorder_buffer.sv]
// ----------------------------------------------------------------------------
// in_order_result_reorder_buffer
// Releases tagged results strictly in sequence order, buffering early ones.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Contents
//  req_     in         req_valid/req_ready  sequence id, main word, debug word
//  rsp_     out        rsp_valid/rsp_ready  sequence id, words, rejected, last
//
//  A request that is stored or rejected leaves the block idle. A request
//  with the expected number drains its buffered successors one per cycle
//  while the output is free, through the slot memory's registered read port.
//  Reset is synchronous; it clears the expected number, the head index, the
//  slot valid bits and the output valid bit. The slot memory is not cleared.
//  A stalled response holds the output register, and no request is taken
//  until it is free and any drain has finished.
//
module in_order_result_reorder_buffer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  rob_pkg::seq_type           req_sequence_id,
   input  rob_pkg::payload_type       req_payload,
   input  rob_pkg::payload_type       req_debug_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rob_pkg::seq_type           rsp_out_sequence_id,
   output rob_pkg::payload_type       rsp_out_payload,
   output rob_pkg::payload_type       rsp_out_debug_payload,
   output logic                       rsp_rejected,
   output logic                       rsp_last
);
   import rob_pkg::*;

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic                 state_ff, state_in;
   seq_type              expected_ff, expected_in;
   idx_type              head_ff, head_in;
   logic [WINDOW-1:0]    slot_valid_ff, slot_valid_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   seq_type              rsp_seq_ff, rsp_seq_in;
   payload_type          rsp_pay_ff, rsp_pay_in;
   payload_type          rsp_dbg_ff, rsp_dbg_in;
   logic                 rsp_rej_ff, rsp_rej_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 out_free;
   logic                 accept;
   seq_type              ahead;
   logic                 in_window;
   logic [IDX_BITS:0]    store_sum;
   idx_type              store_idx;
   idx_type              head_nx;

   logic                 ram_wr_en;
   logic                 ram_rd_en;
   idx_type              ram_rd_addr;
   logic [SLOT_BITS-1:0] ram_rd_data;

   // Handshake on both sides.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   // Distance ahead of the expected number and the slot it maps to.
   assign ahead     = req_sequence_id - expected_ff;
   assign in_window = ahead < seq_type'(WINDOW);
   assign store_sum = {1'b0, head_ff} + {1'b0, ahead[IDX_BITS-1:0]};
   assign store_idx = (store_sum >= (IDX_BITS+1)'(WINDOW)) ?
                      idx_type'(store_sum - (IDX_BITS+1)'(WINDOW)) :
                      idx_type'(store_sum);
   assign head_nx   = next_idx(head_ff);

   // Early requests are written to their slot; drains read the next slot.
   assign ram_wr_en = accept && (ahead != '0) && in_window;

   // Control and output register next values.
   always_comb begin
      state_in      = state_ff;
      expected_in   = expected_ff;
      head_in       = head_ff;
      slot_valid_in = slot_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_seq_in    = rsp_seq_ff;
      rsp_pay_in    = rsp_pay_ff;
      rsp_dbg_in    = rsp_dbg_ff;
      rsp_rej_in    = rsp_rej_ff;
      rsp_last_in   = rsp_last_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = head_nx;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (ahead == '0) begin
                  // Expected number: release it and start a drain if the
                  // next slot is filled.
                  rsp_valid_in = 1'b1;
                  rsp_seq_in   = req_sequence_id;
                  rsp_pay_in   = req_payload;
                  rsp_dbg_in   = req_debug_payload;
                  rsp_rej_in   = 1'b0;
                  rsp_last_in  = !slot_valid_ff[head_nx];
                  expected_in  = expected_ff + seq_type'(1);
                  head_in      = head_nx;
                  if (slot_valid_ff[head_nx]) begin
                     ram_rd_en = 1'b1;
                     state_in  = ST_DRAIN;
                  end
               end else if (in_window) begin
                  // Ahead inside the window: mark the slot as filled.
                  slot_valid_in[store_idx] = 1'b1;
               end else begin
                  // Outside the window: one rejected response.
                  rsp_valid_in = 1'b1;
                  rsp_seq_in   = req_sequence_id;
                  rsp_pay_in   = '0;
                  rsp_dbg_in   = '0;
                  rsp_rej_in   = 1'b1;
                  rsp_last_in  = 1'b1;
               end
            end
         end
         ST_DRAIN: begin
            // Slot at the head has been read; release it when there is room.
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_seq_in             = expected_ff;
               rsp_pay_in             = ram_rd_data[PAYLOAD_BITS-1:0];
               rsp_dbg_in             = ram_rd_data[SLOT_BITS-1:PAYLOAD_BITS];
               rsp_rej_in             = 1'b0;
               rsp_last_in            = !slot_valid_ff[head_nx];
               slot_valid_in[head_ff] = 1'b0;
               expected_in            = expected_ff + seq_type'(1);
               head_in                = head_nx;
               if (slot_valid_ff[head_nx]) begin
                  ram_rd_en = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         expected_ff   <= '0;
         head_ff       <= '0;
         slot_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         expected_ff   <= expected_in;
         head_ff       <= head_in;
         slot_valid_ff <= slot_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Output payload registers.
   always_ff @(posedge clock) begin
      rsp_seq_ff  <= rsp_seq_in;
      rsp_pay_ff  <= rsp_pay_in;
      rsp_dbg_ff  <= rsp_dbg_in;
      rsp_rej_ff  <= rsp_rej_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Slot memory holding the debug and main words of early requests.
   rob_ram #(
      .WIDTH (SLOT_BITS),
      .DEPTH (WINDOW)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (store_idx),
      .wr_data ({req_debug_payload, req_payload}),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_out_sequence_id   = rsp_seq_ff;
   assign rsp_out_payload       = rsp_pay_ff;
   assign rsp_out_debug_payload = rsp_dbg_ff;
   assign rsp_rejected          = rsp_rej_ff;
   assign rsp_last              = rsp_last_ff;

   // The slot of the expected number is never filled while idle.
   a_head_empty_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !slot_valid_ff[head_ff])
      else $error("head slot filled while idle");

   // A drain only runs on a filled head slot.
   a_drain_filled: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |-> slot_valid_ff[head_ff])
      else $error("drain on an empty slot");

   // Every drained response advances the expected number by one.
   a_drain_advance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN && out_free) |=>
         expected_ff == $past(expected_ff) + seq_type'(1))
      else $error("expected number did not advance on drain");

   // A rejected response carries zero words and ends its run.
   a_reject_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_rejected) |->
         (rsp_last && rsp_out_payload == '0 && rsp_out_debug_payload == '0))
      else $error("malformed rejected response");

endmodule

[tb/sv/in_order_result_reorder_buffer_tb.sv]
// ----------------------------------------------------------------------------
// in_order_result_reorder_buffer_tb
// Sends tagged requests in shuffled order, with random gaps on both channels,
// and checks that every response leaves in sequence order. Each response is
// compared field by field with the oldest entry of a queue that a behavioral
// model of the window fills as requests are accepted.
// ----------------------------------------------------------------------------
module in_order_result_reorder_buffer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rob_pkg::*;

   localparam int RANDOM_REQUESTS = 355;
   localparam int IDLE_LIMIT      = 1000;
   localparam int TAIL_CYCLES     = 24;

   // One response as it should appear on the rsp_ channel.
   typedef struct {
      seq_type     seq_id;
      payload_type main_word;
      payload_type dbg_word;
      logic        rejected;
      logic        last;
   } released_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   seq_type     req_sequence_id = '0;
   payload_type req_payload = '0;
   payload_type req_debug_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   seq_type     rsp_out_sequence_id;
   payload_type rsp_out_payload;
   payload_type rsp_out_debug_payload;
   logic        rsp_rejected;
   logic        rsp_last;

   // Window model: next number to release, the slot that belongs to it,
   // and the buffered early arrivals.
   seq_type           expected_seq = '0;
   int unsigned       head_slot = 0;
   logic              slot_full [WINDOW];
   payload_type       slot_main [WINDOW];
   payload_type       slot_dbg [WINDOW];
   released_item_type pending_releases [$];

   int unsigned       mismatch_count = 0;
   int unsigned       idle_cycles = 0;
   bit                no_idle = 1'b0;
   released_item_type want;

   in_order_result_reorder_buffer uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_sequence_id       (req_sequence_id),
      .req_payload           (req_payload),
      .req_debug_payload     (req_debug_payload),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_out_sequence_id   (rsp_out_sequence_id),
      .rsp_out_payload       (rsp_out_payload),
      .rsp_out_debug_payload (rsp_out_debug_payload),
      .rsp_rejected          (rsp_rejected),
      .rsp_last              (rsp_last)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Prints one mismatch line and counts it.
   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned exp_value);
      $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got,
               exp_value);
      mismatch_count++;
   endtask

   function automatic payload_type random_word();
      return {$urandom, $urandom};
   endfunction

   // Updates the window model for one accepted request and queues the
   // responses that it causes.
   function automatic void predict_releases(input seq_type seq_id,
                                            input payload_type main_word,
                                            input payload_type dbg_word);
      seq_type           ahead;
      int unsigned       slot;
      released_item_type item;
      released_item_type run [$];
      ahead = seq_id - expected_seq;
      if (ahead != 0 && ahead < WINDOW) begin
         // Early arrival: park it in its slot, possibly over an older copy.
         slot = (head_slot + ahead) % WINDOW;
         slot_full[slot] = 1'b1;
         slot_main[slot] = main_word;
         slot_dbg[slot]  = dbg_word;
      end else if (ahead != 0) begin
         // Outside the window, which also covers numbers already released.
         item = '{seq_id, 64'd0, 64'd0, 1'b1, 1'b1};
         pending_releases.push_back(item);
      end else begin
         // Expected number: release it, then drain consecutive slots.
         item = '{seq_id, main_word, dbg_word, 1'b0, 1'b0};
         run.push_back(item);
         expected_seq = expected_seq + 1'b1;
         head_slot = (head_slot + 1) % WINDOW;
         while (run.size() < WINDOW && slot_full[head_slot]) begin
            item = '{expected_seq, slot_main[head_slot], slot_dbg[head_slot], 1'b0,
                     1'b0};
            run.push_back(item);
            slot_full[head_slot] = 1'b0;
            expected_seq = expected_seq + 1'b1;
            head_slot = (head_slot + 1) % WINDOW;
         end
         run[run.size() - 1].last = 1'b1;
         foreach (run[i]) begin
            pending_releases.push_back(run[i]);
         end
      end
   endfunction

   // Sends one request. Called and returning just after a falling edge.
   task automatic send_request(input seq_type seq_id, input payload_type main_word,
                               input payload_type dbg_word);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         = 1'b1;
      req_sequence_id   = seq_id;
      req_payload       = main_word;
      req_debug_payload = dbg_word;
      do @(posedge clock); while (!req_ready);
      predict_releases(seq_id, main_word, dbg_word);
      @(negedge clock);
   endtask

   // Holds off new requests until every queued response has come back.
   task automatic wait_for_drain();
      if (pending_releases.size() != 0) begin
         req_valid = 1'b0;
         while (pending_releases.size() != 0) @(negedge clock);
      end
   endtask

   // In-order requests with extreme words, starting at number zero.
   task automatic test_in_order_release();
      send_request(expected_seq, '0, '1);
      send_request(expected_seq, '1, '0);
      send_request(expected_seq, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
      wait_for_drain();
   endtask

   // Fills every slot ahead of the expected number in reverse order, then
   // sends the expected number so that the whole window drains at once.
   task automatic test_full_window_drain();
      seq_type base;
      base = expected_seq;
      for (int d = WINDOW - 1; d >= 1; d--) begin
         send_request(base + seq_type'(d), random_word(), random_word());
      end
      send_request(base, random_word(), random_word());
      wait_for_drain();
   endtask

   // A buffered number written twice must release the second write.
   task automatic test_slot_overwrite();
      seq_type base;
      base = expected_seq;
      send_request(base + 1'b1, random_word(), random_word());
      send_request(base + 1'b1, random_word(), random_word());
      send_request(base, random_word(), random_word());
      wait_for_drain();
   endtask

   // Numbers just past the window, just behind, half way round and the
   // largest number are all rejected and leave the state alone.
   task automatic test_out_of_window();
      send_request(expected_seq + seq_type'(WINDOW), '1, '1);
      send_request(expected_seq - 1'b1, '1, '1);
      send_request(expected_seq ^ 16'h8000, random_word(), random_word());
      send_request('1, '1, '1);
      wait_for_drain();
   endtask

   // Mostly shuffled runs of consecutive numbers, some resent, mixed with
   // rejected numbers and stray early arrivals.
   task automatic test_random_traffic();
      int unsigned sent;
      int unsigned kind;
      int unsigned run_len;
      int unsigned j;
      int          order [WINDOW];
      int          tmp;
      seq_type     base;
      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         no_idle = ($urandom_range(0, 4) == 0);
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, WINDOW)
                                                  : $urandom_range(1, 8);
            for (int i = 0; i < WINDOW; i++) begin
               order[i] = i;
            end
            for (int i = run_len - 1; i >= 1; i--) begin
               j = $urandom_range(0, i);
               tmp = order[i];
               order[i] = order[j];
               order[j] = tmp;
            end
            base = expected_seq;
            for (int i = 0; i < run_len; i++) begin
               send_request(base + seq_type'(order[i]), random_word(), random_word());
               sent++;
               if ($urandom_range(0, 7) == 0) begin
                  send_request(base + seq_type'(order[i]), random_word(), random_word());
                  sent++;
               end
            end
         end else if (kind < 9) begin
            if ($urandom_range(0, 3) == 0) begin
               send_request(expected_seq + seq_type'(WINDOW), random_word(),
                            random_word());
            end else begin
               send_request(expected_seq + seq_type'($urandom_range(WINDOW, 65535)),
                            random_word(), random_word());
            end
            sent++;
         end else begin
            send_request(expected_seq + seq_type'($urandom_range(1, WINDOW - 1)),
                         random_word(), random_word());
            sent++;
         end
         if ($urandom_range(0, 11) == 0) begin
            wait_for_drain();
         end
      end
      no_idle = 1'b0;
      wait_for_drain();
   endtask

   // Stimulus: reset once, then the tests in turn, then the verdict.
   initial begin
      foreach (slot_full[i]) begin
         slot_full[i] = 1'b0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_in_order_release();
      test_full_window_drain();
      test_slot_overwrite();
      test_out_of_window();
      test_random_traffic();
      req_valid = 1'b0;
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_releases.size() != 0) begin
         report_mismatch("missing responses", pending_releases.size(), 0);
      end
      if (mismatch_count == 0) begin
         $display("in_order_result_reorder_buffer test passed");
      end else begin
         $display("in_order_result_reorder_buffer test failed");
      end
      $finish;
   end

   // Response side: a random stall before each response, none in bursts.
   initial begin
      int unsigned stall;
      while (reset) @(negedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 14);
         if (stall != 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Compares each accepted response with the oldest expected one.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_releases.size() == 0) begin
            report_mismatch("unexpected response, sequence id", rsp_out_sequence_id, 0);
         end else begin
            want = pending_releases.pop_front();
            if (rsp_out_sequence_id !== want.seq_id) begin
               report_mismatch("sequence id", rsp_out_sequence_id, want.seq_id);
            end
            if (rsp_out_payload !== want.main_word) begin
               report_mismatch("payload", rsp_out_payload, want.main_word);
            end
            if (rsp_out_debug_payload !== want.dbg_word) begin
               report_mismatch("debug payload", rsp_out_debug_payload, want.dbg_word);
            end
            if (rsp_rejected !== want.rejected) begin
               report_mismatch("rejected", rsp_rejected, want.rejected);
            end
            if (rsp_last !== want.last) begin
               report_mismatch("last", rsp_last, want.last);
            end
         end
      end
   end

   // Watchdog: ends the run when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("in_order_result_reorder_buffer test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

[sim.f]
rtl/rob_pkg.sv
rtl/rob_ram.sv
rtl/in_order_result_reorder_buffer.sv
tb/sv/in_order_result_reorder_buffer_tb.sv
